// ----- rtl/usd_pkg.sv -----
// shared types, constants and helper functions of the utf-8 stream decoder
`timescale 1ns / 1ps

package usd_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BROKEN = 2'd1;
  localparam logic [1:0] STATUS_CUT    = 2'd2;

  // value limits
  localparam logic [31:0] MAX_VALUE   = 32'h7FFF_FFFF;
  localparam logic [30:0] REPLACEMENT = 31'h0000_FFFD;

  // byte classes
  localparam logic [7:0] CONT_SEL  = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] CONT_BITS = 8'h3F;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // input request
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
  } usd_in_t;

  // result request
  typedef struct packed {
    logic [30:0] code_point;
    logic [1:0]  status;
    logic        last_of_run;
  } usd_out_t;

  // one classified input: a first result and an optional plain second byte
  typedef struct packed {
    logic [30:0] first_value;
    logic [1:0]  first_status;
    logic        has_second;
    logic [7:0]  second_byte;
  } usd_entry_t;

  // number of continuation bytes announced by a lead byte
  function automatic logic [2:0] usd_extra(input logic [7:0] b);
    logic [2:0] e;
    priority if (b < 8'hC0) e = 3'd0;
    else if (b < 8'hE0)     e = 3'd1;
    else if (b < 8'hF0)     e = 3'd2;
    else if (b < 8'hF8)     e = 3'd3;
    else if (b < 8'hFC)     e = 3'd4;
    else                    e = 3'd5;
    return e;
  endfunction

  // payload bits kept from the lead byte
  function automatic logic [7:0] usd_lead_mask(input logic [2:0] extra);
    logic [7:0] m;
    unique case (extra)
      3'd1:    m = 8'h1F;
      3'd2:    m = 8'h0F;
      3'd3:    m = 8'h07;
      3'd4:    m = 8'h03;
      3'd5:    m = 8'h03;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // out-of-range values become the replacement character
  function automatic logic [30:0] usd_clip(input logic [31:0] v);
    return (v > MAX_VALUE) ? REPLACEMENT : v[30:0];
  endfunction

endpackage

// ----- rtl/usd_front.sv -----
// front end: accepts bytes, tracks the pending sequence, classifies results
`timescale 1ns / 1ps

module usd_front import usd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  usd_in_t    in_data,
  output logic       push_valid,
  output usd_entry_t push_entry,
  input  logic       q_full
);

  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic        lm_r, lm_nxt;
  logic        accept;
  logic [7:0]  b;
  logic [2:0]  extra;
  logic        is_cont;
  logic [31:0] masked;
  logic [31:0] appended;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.byte_value;
  assign extra    = usd_extra(b);
  assign is_cont  = (b & CONT_SEL) == CONT_TAG;
  assign masked   = lm_r ? acc_r : (acc_r & {24'h0, usd_lead_mask(rem_r)});
  assign appended = {masked[25:0], b[5:0] & CONT_BITS[5:0]};

  // sequence tracking and result classification
  always_comb begin
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    lm_nxt     = lm_r;
    push_valid = 1'b0;
    push_entry = '{first_value: usd_clip(acc_r), first_status: STATUS_OK,
                   has_second: 1'b0, second_byte: b};
    if (accept) begin
      if (in_data.end_of_stream) begin
        // flush a pending partial value
        push_valid              = (rem_r != 3'd0);
        push_entry.first_status = STATUS_CUT;
        acc_nxt                 = '0;
        rem_nxt                 = '0;
        lm_nxt                  = 1'b0;
      end else if (rem_r != 3'd0 && is_cont) begin
        // continuation byte appends six bits
        rem_nxt = rem_r - 3'd1;
        if (rem_r == 3'd1) begin
          push_valid             = 1'b1;
          push_entry.first_value = usd_clip(appended);
          acc_nxt                = '0;
          lm_nxt                 = 1'b0;
        end else begin
          acc_nxt = appended;
          lm_nxt  = 1'b1;
        end
      end else if (rem_r != 3'd0) begin
        // broken sequence, the byte then starts over as a lead
        push_valid              = 1'b1;
        push_entry.first_status = STATUS_BROKEN;
        if (extra == 3'd0) begin
          push_entry.has_second = 1'b1;
          acc_nxt               = '0;
          rem_nxt               = '0;
        end else begin
          acc_nxt = {24'h0, b};
          rem_nxt = extra;
        end
        lm_nxt = 1'b0;
      end else begin
        // idle: single byte or new lead
        if (extra == 3'd0) begin
          push_valid             = 1'b1;
          push_entry.first_value = {23'h0, b};
        end else begin
          acc_nxt = {24'h0, b};
          rem_nxt = extra;
          lm_nxt  = 1'b0;
        end
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= '0;
      lm_r  <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      lm_r  <= lm_nxt;
    end
  end

endmodule

// ----- rtl/usd_queue.sv -----
// short queue of classified entries between front and back
`timescale 1ns / 1ps

module usd_queue import usd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  usd_entry_t push_entry,
  output logic       q_full,
  input  logic       pop,
  output usd_entry_t head,
  output logic       q_empty
);

  usd_entry_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign q_full  = (count_r == QCNT_W'(QDEPTH));
  assign q_empty = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push_valid && !q_full;
  assign do_pop  = pop && !q_empty;

  // pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/usd_back.sv -----
// back end: expands queue entries into result requests in an output register
`timescale 1ns / 1ps

module usd_back import usd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  usd_entry_t head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output usd_out_t   out_data
);

  logic       out_valid_r, out_valid_nxt;
  usd_out_t   out_data_r, out_data_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] sec_byte_r, sec_byte_nxt;
  logic       load;

  assign load      = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pick the next result: a pending second byte first, then the queue head
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pend_nxt      = pend_r;
    sec_byte_nxt  = sec_byte_r;
    pop           = 1'b0;
    if (load) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{code_point: {23'h0, sec_byte_r}, status: STATUS_OK,
                          last_of_run: 1'b1};
        pend_nxt      = 1'b0;
      end else if (!q_empty) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{code_point: head.first_value, status: head.first_status,
                          last_of_run: !head.has_second};
        pend_nxt      = head.has_second;
        sec_byte_nxt  = head.second_byte;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    sec_byte_r <= sec_byte_nxt;
  end

endmodule

// ----- rtl/utf8_stream_decoder_core.sv -----
// top level of the utf-8 stream decoder: front, queue and back joined
//
//  channel   dir  handshake             payload
//  in_       in   in_valid / in_ready   usd_in_t  (byte_value, end_of_stream)
//  out_      out  out_valid / out_ready usd_out_t (code_point, status, last_of_run)
//
// one byte is accepted per cycle while the queue is not full; decoder state updates in the front in that cycle
// a result is written to a queue slot when its byte is accepted, then loaded into the output register
// a broken sequence followed by a single byte yields two results from one queue entry
// the four-entry queue absorbs those second results and output stalls
// in_ready drops only while the queue holds four entries
// rst_n is synchronous, active low; it clears state, queue and output valid
`timescale 1ns / 1ps

module utf8_stream_decoder_core import usd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  usd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output usd_out_t out_data
);

  logic       push_valid;
  usd_entry_t push_entry;
  logic       q_full;
  logic       q_empty;
  logic       pop;
  usd_entry_t head;

  // byte classification
  usd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  // decoupling queue
  usd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .q_full     (q_full),
    .pop        (pop),
    .head       (head),
    .q_empty    (q_empty)
  );

  // result delivery
  usd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/usd_checker.sv -----
// port-level checks of the utf-8 stream decoder and their binding
`timescale 1ns / 1ps

module usd_checker import usd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input usd_out_t out_data
);

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a sequence cut by end of stream is always the only result of its request
  a_cut_last: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_data.status == STATUS_CUT |-> out_data.last_of_run)
    else $error("cut result not last of run");

  // only a broken sequence can be followed by a second result
  a_first_broken: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_data.last_of_run |-> out_data.status == STATUS_BROKEN)
    else $error("non-last result without broken status");

  // the second result of a run is a plain byte
  a_second_plain: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_ready && !out_data.last_of_run |=>
        out_valid && out_data.last_of_run && out_data.status == STATUS_OK &&
        out_data.code_point < 31'h0000_00C0)
    else $error("second result of run malformed");

endmodule

bind utf8_stream_decoder_core usd_checker u_usd_checker (.*);

// ----- dv/tb.sv -----
// testbench of the utf-8 stream decoder core with a self-contained decode predictor
`timescale 1ns / 1ps

module tb;
  import usd_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int RESET_CYC  = 12;
  localparam int RAND_ITEMS = 950;
  localparam int CYCLE_MAX  = 300000;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE_CYC = 12;

  // one queued byte request, optionally held back until all results are in
  typedef struct {
    usd_in_t req;
    bit      wait_drain;
  } byte_req_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  usd_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  usd_out_t out_data;

  byte_req_t   byte_stream[$];
  usd_out_t    expected_chars[$];

  // decoder state tracked by the predictor
  logic [31:0] acc_value;
  logic [2:0]  conts_left;
  logic        lead_stripped;

  int  fails;
  int  bytes_total;
  int  bytes_accepted;
  int  chars_seen;
  int  cycle_count;
  bit  in_taken;
  bit  out_taken;
  int  send_gap;
  int  recv_hold;
  bit  send_burst;
  bit  recv_burst;
  bit  long_hold_done;

  utf8_stream_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // number of continuation bytes a lead announces, from its leading ones
  function automatic logic [2:0] conts_for_lead(input logic [7:0] b);
    casez (b)
      8'b110?????: return 3'd1;
      8'b1110????: return 3'd2;
      8'b11110???: return 3'd3;
      8'b111110??: return 3'd4;
      8'b111111??: return 3'd5;
      default:     return 3'd0;
    endcase
  endfunction

  // payload bits of the lead that survive the first continuation
  function automatic logic [7:0] strip_mask(input logic [2:0] n);
    if (n >= 3'd5) return 8'h03;
    return 8'hFF >> (n + 3'd2);
  endfunction

  function automatic usd_out_t make_char(input logic [31:0] v, input logic [1:0] st);
    usd_out_t r;
    r.code_point  = (v > MAX_VALUE) ? REPLACEMENT : v[30:0];
    r.status      = st;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // advance the predictor by one byte request and queue the characters it yields
  task automatic decode_byte(input usd_in_t req);
    usd_out_t   chars[$];
    logic [7:0] b;
    logic [2:0] n;
    bit         take_lead;
    b = req.byte_value;
    take_lead = 1'b1;
    if (req.end_of_stream) begin
      if (conts_left != 3'd0) chars.push_back(make_char(acc_value, STATUS_CUT));
      acc_value = '0;
      conts_left = '0;
      lead_stripped = 1'b0;
      take_lead = 1'b0;
    end else if (conts_left != 3'd0) begin
      if ((b & CONT_SEL) == CONT_TAG) begin
        if (!lead_stripped) begin
          acc_value = acc_value & {24'h0, strip_mask(conts_left)};
          lead_stripped = 1'b1;
        end
        acc_value = {acc_value[25:0], b[5:0]};
        conts_left = conts_left - 3'd1;
        if (conts_left == 3'd0) begin
          chars.push_back(make_char(acc_value, STATUS_OK));
          acc_value = '0;
          lead_stripped = 1'b0;
        end
        take_lead = 1'b0;
      end else begin
        chars.push_back(make_char(acc_value, STATUS_BROKEN));
        acc_value = '0;
        conts_left = '0;
        lead_stripped = 1'b0;
      end
    end
    if (take_lead) begin
      n = conts_for_lead(b);
      if (n == 3'd0) begin
        chars.push_back(make_char({24'h0, b}, STATUS_OK));
      end else begin
        acc_value = {24'h0, b};
        conts_left = n;
        lead_stripped = 1'b0;
      end
    end
    if (chars.size() > 0) chars[chars.size() - 1].last_of_run = 1'b1;
    foreach (chars[i]) expected_chars.push_back(chars[i]);
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eos, input bit drain);
    byte_req_t e;
    e.req.byte_value    = b;
    e.req.end_of_stream = eos;
    e.wait_drain        = drain;
    byte_stream.push_back(e);
  endtask

  function automatic logic [7:0] lead_of(input int n);
    case (n)
      1:       return 8'($urandom_range(8'hC0, 8'hDF));
      2:       return 8'($urandom_range(8'hE0, 8'hEF));
      3:       return 8'($urandom_range(8'hF0, 8'hF7));
      4:       return 8'($urandom_range(8'hF8, 8'hFB));
      default: return 8'($urandom_range(8'hFC, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // any byte outside 0x80-0xbf
  function automatic logic [7:0] non_cont_byte();
    int v;
    v = $urandom_range(0, 191);
    if (v >= 128) v += 64;
    return 8'(v);
  endfunction

  // sender: presents queued byte requests with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // request still waiting for acceptance
    end else begin
      in_taken = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (byte_stream.size() == 0 ||
                   (byte_stream[0].wait_drain && expected_chars.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_data  <= byte_stream[0].req;
        in_valid <= 1'b1;
        byte_stream.pop_front();
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 8);
      end
    end
  end

  // receiver: random stalls after each result, one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        if (!long_hold_done && chars_seen >= 200) begin
          long_hold_done = 1'b1;
          recv_hold = LONG_HOLD;
        end else begin
          if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
          recv_hold = recv_burst ? 0 : $urandom_range(0, 8);
        end
      end
      if (recv_hold != 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predicts on accepted bytes, checks accepted results
  always @(posedge clk) begin
    usd_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_byte(in_data);
        in_taken = 1'b1;
        bytes_accepted++;
      end
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        chars_seen++;
        if (expected_chars.size() == 0) begin
          $error("unexpected result: code_point %h status %0d last_of_run %0b",
                 out_data.code_point, out_data.status, out_data.last_of_run);
          fails++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.code_point !== want.code_point) begin
            $error("code_point: expected %h, actual %h", want.code_point, out_data.code_point);
            fails++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            fails++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b",
                   want.last_of_run, out_data.last_of_run);
            fails++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int r;
    int n;
    int k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    acc_value = '0;
    conts_left = '0;
    lead_stripped = 1'b0;
    fails = 0;
    bytes_accepted = 0;
    chars_seen = 0;
    cycle_count = 0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    send_gap = 0;
    recv_hold = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    long_hold_done = 1'b0;

    // directed: plain bytes, stray continuations, full sequences
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h7F, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'hBF, 1'b0, 1'b0);
    queue_byte(8'hC2, 1'b0, 1'b0);
    queue_byte(8'hA9, 1'b0, 1'b0);
    queue_byte(8'hE2, 1'b0, 1'b0);
    queue_byte(8'h82, 1'b0, 1'b0);
    queue_byte(8'hAC, 1'b0, 1'b0);
    // largest six-byte value within the limit
    queue_byte(8'hFD, 1'b0, 1'b0);
    repeat (5) queue_byte(8'hBF, 1'b0, 1'b0);
    // value above the limit turns into the replacement character
    queue_byte(8'hFE, 1'b0, 1'b0);
    repeat (5) queue_byte(8'h80, 1'b0, 1'b0);
    // lead broken by a plain byte: two results
    queue_byte(8'hC3, 1'b0, 1'b0);
    queue_byte(8'h41, 1'b0, 1'b0);
    // end marker while idle, then a sequence cut by the end marker
    queue_byte(8'hFF, 1'b1, 1'b0);
    queue_byte(8'hF0, 1'b0, 1'b0);
    queue_byte(8'h9F, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);

    // random: mostly well-formed sequences, some broken ones and noise
    k = 0;
    while (k < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(0, 5);
        if (n == 0) begin
          queue_byte(8'($urandom_range(0, 127)), 1'b0, k == 0 || k == 500);
        end else begin
          queue_byte(lead_of(n), 1'b0, k == 0 || k == 500);
          repeat (n) queue_byte(cont_byte(), 1'b0, 1'b0);
        end
      end else if (r < 82) begin
        n = $urandom_range(1, 5);
        queue_byte(lead_of(n), 1'b0, k == 0 || k == 500);
        repeat ($urandom_range(0, n - 1)) queue_byte(cont_byte(), 1'b0, 1'b0);
        if ($urandom_range(0, 1) == 0) queue_byte(non_cont_byte(), 1'b0, 1'b0);
        else queue_byte(8'($urandom), 1'b1, 1'b0);
      end else if (r < 92) begin
        queue_byte(8'($urandom), 1'b0, k == 0 || k == 500);
      end else begin
        queue_byte(8'($urandom), 1'b1, k == 0 || k == 500);
      end
      k = byte_stream.size() - 19;
    end
    bytes_total = byte_stream.size();

    // reset
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for all bytes and all results, then let the pipeline settle
    while (bytes_accepted < bytes_total || expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d expected results never arrived", expected_chars.size());
      fails++;
    end
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
